>>> rtl/tta2d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tta2d_pkg
// Shared widths, register indexes, limits and the tiled index function for
// the 2D tiled texel address block.
// ----------------------------------------------------------------------------
package tta2d_pkg;

    localparam int COORD_W  = 13;
    localparam int PITCH_W  = 14;
    localparam int LOG2_W   = 3;
    localparam int SRC_W    = 25;
    localparam int INDEX_W  = 32;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_PITCH_TEXELS     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOG2_BLOCK_BYTES = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TILED_MODE       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_BLOCKS    = 3'd3;

    localparam logic [PITCH_W-1:0] MAX_PITCH      = 14'd8192;
    localparam logic [LOG2_W-1:0]  MAX_LOG2_BLOCK = 3'd4;

    localparam logic [LOG2_W-1:0] RESET_LOG2_BLOCK = 3'd2;

    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [INDEX_W-1:0] index_t;

    typedef struct packed {
        index_t block_index;
        logic   fault;
    } result_t;

    // Byte offset inside 32x32 macro tiles with bank and pipe interleave,
    // scaled back to blocks.
    function automatic index_t tile_index(
        input coord_t             x,
        input coord_t             y,
        input logic [PITCH_W-1:0] pitch,
        input logic [LOG2_W-1:0]  lg
    );
        logic [PITCH_W-1:0] wide;
        logic [8:0]         tiles_per_row;
        index_t             macro_base;
        index_t             macro;
        index_t             micro;
        index_t             off;
        index_t             mixed;
        logic [4:0]         macro_shift;
        logic [1:0]         bank;
        begin
            wide          = (pitch + 14'd31) & ~14'd31;
            tiles_per_row = wide[PITCH_W-1:5];
            macro_base    = {24'd0, x[12:5]}
                          + ({24'd0, y[12:5]} * {23'd0, tiles_per_row});
            macro_shift   = {2'd0, lg} + 5'd7;
            macro         = macro_base << macro_shift;
            micro         = ({29'd0, x[2:0]} + ({28'd0, y[3:1], 1'b0} << 2)) << lg;
            off           = macro + ((micro & ~32'hF) << 1) + (micro & 32'hF)
                          + ({31'd0, y[0]} << 4);
            bank          = {y[3], 1'b0} + x[4:3];
            mixed         = ((off & ~32'h1FF) << 3)
                          + ({27'd0, y[4], 4'd0} << 7)
                          + ((off & 32'h1C0) << 2)
                          + ({30'd0, bank} << 6)
                          + (off & 32'h3F);
            tile_index    = mixed >> lg;
        end
    endfunction

endpackage

>>> rtl/tiled_texel_address_2d.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tiled_texel_address_2d
// Texel coordinate to block index, tiled or linear layout, with fault flag.
// Input word held in the input register; result word held in the result register.
// Throughput: 1 word per cycle unless m_axis_tready stalls the result; one
//   pass through the index logic between the input and result registers.
// Reset: both pipeline stages empty; registers pitch 0, log2 2, linear, size 0.
// ----------------------------------------------------------------------------
module tiled_texel_address_2d (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [24:0] cfg_data,
    // input words
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // [12:0] coord_x, [25:13] coord_y, rest zero
    // result words
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // [31:0] block_index
    output logic        m_axis_tuser   // [0] fault
);

    logic [tta2d_pkg::PITCH_W-1:0] pitch_reg;
    logic [tta2d_pkg::LOG2_W-1:0]  log2_reg;
    logic                          tiled_reg;
    logic [tta2d_pkg::SRC_W-1:0]   source_reg;

    logic                in_valid_reg;
    tta2d_pkg::coord_t   x_reg;
    tta2d_pkg::coord_t   y_reg;
    logic                out_valid_reg;
    tta2d_pkg::result_t  res_reg;
    tta2d_pkg::result_t  res_next;

    logic                out_free;
    tta2d_pkg::index_t   idx;
    logic                bad_param;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pitch_reg  <= '0;
            log2_reg   <= tta2d_pkg::RESET_LOG2_BLOCK;
            tiled_reg  <= 1'b0;
            source_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                tta2d_pkg::REG_PITCH_TEXELS:     pitch_reg  <= cfg_data[13:0];
                tta2d_pkg::REG_LOG2_BLOCK_BYTES: log2_reg   <= cfg_data[2:0];
                tta2d_pkg::REG_TILED_MODE:       tiled_reg  <= cfg_data[0];
                tta2d_pkg::REG_SOURCE_BLOCKS:    source_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            x_reg <= s_axis_tdata[12:0];
            y_reg <= s_axis_tdata[25:13];
        end
    end

    assign bad_param = (pitch_reg == '0) || (pitch_reg > tta2d_pkg::MAX_PITCH)
                    || ({1'b0, x_reg} >= pitch_reg)
                    || (log2_reg > tta2d_pkg::MAX_LOG2_BLOCK);

    always_comb
    begin
        if (tiled_reg)
        begin
            idx = tta2d_pkg::tile_index(x_reg, y_reg, pitch_reg, log2_reg);
        end
        else
        begin
            idx = ({19'd0, y_reg} * {18'd0, pitch_reg}) + {19'd0, x_reg};
        end
        res_next.fault       = bad_param || (idx >= {7'd0, source_reg});
        res_next.block_index = res_next.fault ? '0 : idx;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && in_valid_reg)
        begin
            res_reg <= res_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = res_reg.block_index;
    assign m_axis_tuser  = res_reg.fault;

`ifndef ASSERT_OFF
    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("fault result with nonzero block index");

    a_in_load: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> in_valid_reg)
        else $error("accepted word lost from input stage");

    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_free) |=> m_axis_tvalid)
        else $error("input stage word not moved to result stage");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (in_valid_reg && out_valid_reg && !m_axis_tready))
        else $error("input stalled with room in pipeline");
`endif

endmodule
